// ===== rtl/bcke_pkg.sv =====
// ----------------------------------------------------------------------------
// bcke_pkg
// Shared constants for the button change key event block.
// ----------------------------------------------------------------------------
`default_nettype none

package bcke_pkg;

   localparam int BUTTON_W          = 26;
   localparam int KEY_ID_W          = 5;
   localparam int FUNCTION_KEYS_DEF = 12;
   localparam int WEAPON_KEYS_DEF   = 7;
   localparam int FKEY_FIRST_BIT    = 13;
   localparam int TAB_BIT           = 25;
   localparam int PLAIN_SLOTS       = 11;
   localparam int ID_WEAPON_BASE    = 11;

   typedef logic [BUTTON_W-1:0] buttons_type;
   typedef logic [KEY_ID_W-1:0] key_id_type;

endpackage

`default_nettype wire

// ===== rtl/bcke_if.sv =====
// ----------------------------------------------------------------------------
// bcke_if
// Handshake channels: button snapshots in, key events out.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcke_req_if;
   logic                  valid;
   logic                  ready;
   bcke_pkg::buttons_type buttons;

   modport source (output valid, output buttons, input ready);
   modport sink (input valid, input buttons, output ready);
endinterface

interface bcke_rsp_if;
   logic                 valid;
   logic                 ready;
   bcke_pkg::key_id_type key_id;
   logic                 key_down;
   logic                 last_event;

   modport source (output valid, output key_id, output key_down, output last_event,
                   input ready);
   modport sink (input valid, input key_id, input key_down, input last_event,
                 output ready);
endinterface

`default_nettype wire

// ===== rtl/bcke_scan.sv =====
// ----------------------------------------------------------------------------
// bcke_scan
// Serial slot scan to the event register, one slot per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module bcke_scan #(
   parameter int SLOTS = bcke_pkg::PLAIN_SLOTS + bcke_pkg::FUNCTION_KEYS_DEF +
                         bcke_pkg::WEAPON_KEYS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire logic [SLOTS-1:0]     load_chg,
   input  wire logic [SLOTS-1:0]     load_lvl,
   input  wire bcke_pkg::key_id_type slot_id [SLOTS],
   output      logic                 idle,
   bcke_rsp_if.source                rsp
);
   import bcke_pkg::*;

   localparam int SW = $clog2(SLOTS);

   logic [SLOTS-1:0] chg_ff, chg_in;
   logic [SLOTS-1:0] lvl_ff, lvl_in;
   logic [SW-1:0]    slot_ff, slot_in;
   logic             valid_ff, valid_in;
   key_id_type       key_id_ff, key_id_in;
   logic             down_ff, down_in;
   logic             last_ff, last_in;
   logic             out_free;
   logic             advance;
   logic             out_load;
   logic [SLOTS-1:0] rest;

   assign idle     = (chg_ff == '0);
   assign out_free = !valid_ff || rsp.ready;
   assign advance  = !idle && (!chg_ff[0] || out_free);
   assign out_load = advance && chg_ff[0];
   assign rest     = chg_ff >> 1;

   always_comb begin
      chg_in    = chg_ff;
      lvl_in    = lvl_ff;
      slot_in   = slot_ff;
      valid_in  = valid_ff;
      key_id_in = key_id_ff;
      down_in   = down_ff;
      last_in   = last_ff;
      if (load) begin
         chg_in  = load_chg;
         lvl_in  = load_lvl;
         slot_in = '0;
      end else if (advance) begin
         chg_in  = rest;
         lvl_in  = lvl_ff >> 1;
         slot_in = slot_ff + SW'(1);
      end
      if (out_load) begin
         valid_in  = 1'b1;
         key_id_in = slot_id[slot_ff];
         down_in   = lvl_ff[0];
         last_in   = (rest == '0);
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chg_ff   <= '0;
         slot_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         chg_ff   <= chg_in;
         slot_ff  <= slot_in;
         valid_ff <= valid_in;
      end
      lvl_ff    <= lvl_in;
      key_id_ff <= key_id_in;
      down_ff   <= down_in;
      last_ff   <= last_in;
   end

   assign rsp.valid      = valid_ff;
   assign rsp.key_id     = key_id_ff;
   assign rsp.key_down   = down_ff;
   assign rsp.last_event = last_ff;

   // a new snapshot never lands on a scan in progress
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      load |-> idle)
      else $error("snapshot loaded while scan busy");

   // an event that is not the last leaves more changes to scan
   a_more_pending: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !last_ff) |-> !idle)
      else $error("non-final event with nothing left to scan");

   // the final event empties the scan
   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      (out_load && last_in) |=> idle)
      else $error("scan not empty after final event");

   // the slot counter stays inside the slot list while scanning
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      !idle |-> (int'(slot_ff) < SLOTS))
      else $error("slot counter out of range");

endmodule

`default_nettype wire

// ===== rtl/button_change_key_events_core.sv =====
// ----------------------------------------------------------------------------
// button_change_key_events_core
// Compares each button snapshot with the previous one and emits key events.
// ----------------------------------------------------------------------------
// the first event is registered once the key slot scan reaches the first changed slot
// a snapshot is worked through by that scan, which inspects one slot per cycle while
// the output does not stall; it ends after the last change
// output stalls hold the scan on the pending event
// reset clears the previous snapshot to all released and empties the scan
`default_nettype none

module button_change_key_events_core #(
   parameter int FUNCTION_KEYS = bcke_pkg::FUNCTION_KEYS_DEF,
   parameter int WEAPON_KEYS   = bcke_pkg::WEAPON_KEYS_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   bcke_req_if.sink  req_bus,
   bcke_rsp_if.source rsp_bus
);
   import bcke_pkg::*;

   localparam int NW    = (WEAPON_KEYS < FUNCTION_KEYS) ? WEAPON_KEYS : FUNCTION_KEYS;
   localparam int SLOTS = PLAIN_SLOTS + FUNCTION_KEYS + NW;

   buttons_type      prev_ff, prev_in;
   buttons_type      now_b;
   logic             accept;
   logic             idle;
   logic [SLOTS-1:0] lvl_now, lvl_old;
   key_id_type       slot_id [SLOTS];

   assign now_b  = req_bus.buttons;
   assign accept = req_bus.valid && req_bus.ready;
   assign req_bus.ready = idle;
   assign prev_in = accept ? now_b : prev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else begin
         prev_ff <= prev_in;
      end
   end

   // plain keys
   assign lvl_now[0]  = now_b[0];
   assign lvl_old[0]  = prev_ff[0];
   assign lvl_now[1]  = now_b[1] | now_b[4];
   assign lvl_old[1]  = prev_ff[1] | prev_ff[4];
   assign lvl_now[2]  = now_b[5];
   assign lvl_old[2]  = prev_ff[5];
   assign lvl_now[10] = now_b[TAB_BIT];
   assign lvl_old[10] = prev_ff[TAB_BIT];

   for (genvar k = 0; k < PLAIN_SLOTS; k++) begin : g_plain_id
      assign slot_id[k] = KEY_ID_W'(k);
   end

   for (genvar k = 3; k < 10; k++) begin : g_plain
      assign lvl_now[k] = now_b[k+3];
      assign lvl_old[k] = prev_ff[k+3];
   end

   // function keys, weapon slot ahead of menu slot
   for (genvar i = 0; i < FUNCTION_KEYS; i++) begin : g_fkey
      if (i < NW) begin : g_pair
         localparam int WS = PLAIN_SLOTS + 2 * i;
         assign lvl_now[WS]   = now_b[FKEY_FIRST_BIT+i] & now_b[0];
         assign lvl_old[WS]   = prev_ff[FKEY_FIRST_BIT+i] & prev_ff[0];
         assign slot_id[WS]   = KEY_ID_W'(ID_WEAPON_BASE + i);
         assign lvl_now[WS+1] = now_b[FKEY_FIRST_BIT+i] & ~now_b[0];
         assign lvl_old[WS+1] = prev_ff[FKEY_FIRST_BIT+i] & ~prev_ff[0];
         assign slot_id[WS+1] = KEY_ID_W'(ID_WEAPON_BASE + WEAPON_KEYS + i);
      end else begin : g_menu
         localparam int MS = PLAIN_SLOTS + NW + i;
         assign lvl_now[MS] = now_b[FKEY_FIRST_BIT+i] & ~now_b[0];
         assign lvl_old[MS] = prev_ff[FKEY_FIRST_BIT+i] & ~prev_ff[0];
         assign slot_id[MS] = KEY_ID_W'(ID_WEAPON_BASE + WEAPON_KEYS + i);
      end
   end

   bcke_scan #(
      .SLOTS (SLOTS)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .load     (accept),
      .load_chg (lvl_now ^ lvl_old),
      .load_lvl (lvl_now),
      .slot_id  (slot_id),
      .idle     (idle),
      .rsp      (rsp_bus)
   );

endmodule

`default_nettype wire
